// ===== hdl/cfatan_pkg.sv =====
// shared types and constants of the continued-fraction arctangent unit
// used by cfatan_div and continued_fraction_arctangent_unit_core
package cfatan_pkg;

   localparam int FRACTION_TERMS    = 24;
   localparam int OPERAND_FRAC_BITS = 16;
   localparam int OPERAND_W         = 32;
   localparam int ANGLE_W           = 32;
   localparam int ANGLE_FRAC        = 28;
   localparam int RATIO_FRAC        = 30;
   localparam int CF_FRAC           = 24;
   localparam int DIVIDEND_W        = 64;
   localparam int DIVISOR_W         = 32;
   localparam int QUOT_W            = 31;
   localparam int SQ_W              = 25;
   localparam int C_W               = 29;
   localparam int ZSQ_W             = 12;
   localparam int ROOT_STEPS        = RATIO_FRAC + 1;
   localparam int RAD_W             = 2 * RATIO_FRAC + 1;
   localparam int ROOT_W            = 2 * RATIO_FRAC + 2;

   localparam logic [OPERAND_W-1:0] OPERAND_ONE = OPERAND_W'(1) << OPERAND_FRAC_BITS;
   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q28 = 32'sd421657428;
   localparam logic signed [ANGLE_W-1:0] PI_Q28      = 32'sd843314857;

   typedef enum logic [1:0] {
      ACT_ATAN  = 2'd0,
      ACT_ATAN2 = 2'd1,
      ACT_ASIN  = 2'd2,
      ACT_ACOS  = 2'd3
   } action_type;

   typedef struct packed {
      action_type                   action;
      logic signed [OPERAND_W-1:0]  y_value;
      logic signed [OPERAND_W-1:0]  x_value;
   } req_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle;
      logic                      domain_error;
   } rsp_type;

   // flags and operands that travel beside the arithmetic
   typedef struct packed {
      logic              yneg;
      logic              xneg;
      logic              flip;
      logic              zero_pair;
      logic              x_zero;
      logic              derr;
      logic              is_acos;
      logic [QUOT_W-1:0] u;
      logic [SQ_W-1:0]   sq;
   } side_type;

   typedef struct packed {
      logic                  valid;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
      side_type              side;
   } div_req_type;

   typedef struct packed {
      logic              valid;
      logic [QUOT_W-1:0] quotient;
      side_type          side;
   } div_rsp_type;

endpackage

// ===== hdl/cfatan_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on cfatan_pkg for widths and the request and response structs
module cfatan_div import cfatan_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   typedef struct packed {
      logic [DIVIDEND_W-1:0] rem;
      logic [DIVISOR_W-1:0]  divisor;
      logic [QUOT_W-1:0]     quot;
      side_type              side;
   } step_type;

   function automatic step_type div_step(step_type s, int b);
      step_type              r;
      logic [DIVIDEND_W-1:0] shifted;
      r = s;
      shifted = DIVIDEND_W'(s.divisor) << b;
      if (s.rem >= shifted) begin
         r.rem  = s.rem - shifted;
         r.quot = s.quot | (QUOT_W'(1) << b);
      end
      return r;
   endfunction

   step_type          step_ff [0:QUOT_W-1];
   logic [QUOT_W-1:0] step_vld_ff;
   step_type          entry;

   always_comb begin
      entry.rem     = div_req.dividend;
      entry.divisor = div_req.divisor;
      entry.quot    = '0;
      entry.side    = div_req.side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_vld_ff <= '0;
      end else begin
         step_vld_ff <= {step_vld_ff[QUOT_W-2:0], div_req.valid};
      end
      step_ff[0] <= div_step(entry, QUOT_W - 1);
      for (int j = 1; j < QUOT_W; j++) begin
         step_ff[j] <= div_step(step_ff[j-1], QUOT_W - 1 - j);
      end
   end

   always_comb begin
      div_rsp.valid    = step_vld_ff[QUOT_W-1];
      div_rsp.quotient = step_ff[QUOT_W-1].quot;
      div_rsp.side     = step_ff[QUOT_W-1].side;
   end

endmodule

// ===== hdl/continued_fraction_arctangent_unit_core.sv =====
// atan / atan2 / asin / acos by a 24-term continued fraction, fully pipelined
// throughput: one transaction per cycle while busy is low; busy drops at the clock edge that samples reset low
// the pipeline holds the 26 restoring dividers of 31 stages each plus the 31-step root
// reset: synchronous, active high, clears every valid bit and holds busy high while asserted
// depends on cfatan_pkg and cfatan_div
module continued_fraction_arctangent_unit_core import cfatan_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   // accept edge to the edge that takes the result
   localparam int LATENCY = 3 + ROOT_STEPS + 1 + QUOT_W + 1
                            + FRACTION_TERMS * (1 + QUOT_W) + 1 + QUOT_W + 3;
   localparam int SQ_SHIFT   = 2 * RATIO_FRAC - CF_FRAC;
   localparam int ATAN_SHIFT = ANGLE_FRAC + CF_FRAC - RATIO_FRAC;
   localparam int PROD_W     = ZSQ_W + SQ_W;

   // operands after decode
   typedef struct packed {
      logic [OPERAND_W-1:0]  ym;
      logic [OPERAND_W-1:0]  xm;
      logic [RATIO_FRAC:0]   big;
      logic                  use_root;
      side_type              side;
   } dec_type;

   // one step of the digit-by-digit square root
   typedef struct packed {
      logic [RAD_W-1:0]     rad;
      logic [ROOT_W-1:0]    res;
      logic [OPERAND_W-1:0] ym;
      logic [OPERAND_W-1:0] xm;
      logic                 use_root;
      side_type             side;
   } root_type;

   function automatic root_type root_step(root_type s, int k);
      root_type          r;
      logic [ROOT_W-1:0] bit_v;
      logic [ROOT_W-1:0] trial;
      r = s;
      bit_v = ROOT_W'(1) << (2 * k);
      trial = s.res + bit_v;
      if (ROOT_W'(s.rad) >= trial) begin
         r.rad = s.rad - trial[RAD_W-1:0];
         r.res = (s.res >> 1) + bit_v;
      end else begin
         r.res = s.res >> 1;
      end
      return r;
   endfunction

   // c = (z^2 sq 2^24 + den/2) / den with den = (2z+1) 2^24 + c_prev
   function automatic div_req_type term_req(div_rsp_type r, int z);
      div_req_type          q;
      logic [DIVISOR_W-1:0] den;
      logic [PROD_W-1:0]    prod;
      den  = DIVISOR_W'((2 * z + 1) << CF_FRAC) + DIVISOR_W'(r.quotient[C_W-1:0]);
      prod = PROD_W'(ZSQ_W'(z * z)) * PROD_W'(r.side.sq);
      q.valid    = r.valid;
      q.dividend = (DIVIDEND_W'(prod) << CF_FRAC) + DIVIDEND_W'(den >> 1);
      q.divisor  = den;
      q.side     = r.side;
      return q;
   endfunction

   logic                       busy_ff;
   logic                       in_vld_ff;
   req_type                    in_req_ff;
   logic                       dec_vld_ff;
   dec_type                    dec_ff;
   dec_type                    dec_in;
   root_type                   root_ff [0:ROOT_STEPS];
   root_type                   root_in;
   logic [ROOT_STEPS:0]        root_vld_ff;
   div_req_type                pre_ff;
   div_req_type                pre_in;
   div_rsp_type                ratio_rsp;
   logic                       sq_vld_ff;
   side_type                   sq_side_ff;
   side_type                   sq_side_in;
   div_rsp_type                term_out [0:FRACTION_TERMS];
   div_req_type                term_req_ff [0:FRACTION_TERMS-1];
   div_req_type                fin_ff;
   div_req_type                fin_in;
   div_rsp_type                fin_rsp;
   logic                       p1_vld_ff;
   logic signed [ANGLE_W-1:0]  p1_angle_ff;
   logic signed [ANGLE_W-1:0]  p1_angle_in;
   side_type                   p1_side_ff;
   logic                       p2_vld_ff;
   logic signed [ANGLE_W-1:0]  p2_angle_ff;
   logic signed [ANGLE_W-1:0]  p2_angle_in;
   side_type                   p2_side_ff;
   logic                       rsp_vld_ff;
   rsp_type                    rsp_ff;
   rsp_type                    rsp_in;

   // ---------------------------------------------------------------- handshake
   assign busy        = busy_ff;
   assign rsp_strobe  = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   // ---------------------------------------------------------------- decode
   // atan(x) runs as atan2(x, 1); asin and acos run as atan2(x, sqrt(1 - x^2))
   always_comb begin
      logic [OPERAND_W-1:0] x_mag;
      logic [OPERAND_W-1:0] y_mag;
      x_mag = in_req_ff.x_value[OPERAND_W-1] ? OPERAND_W'(-in_req_ff.x_value)
                                             : in_req_ff.x_value;
      y_mag = in_req_ff.y_value[OPERAND_W-1] ? OPERAND_W'(-in_req_ff.y_value)
                                             : in_req_ff.y_value;
      dec_in = '0;
      case (in_req_ff.action)
         ACT_ATAN: begin
            dec_in.ym        = x_mag;
            dec_in.xm        = OPERAND_ONE;
            dec_in.side.yneg = in_req_ff.x_value[OPERAND_W-1];
         end
         ACT_ATAN2: begin
            dec_in.ym        = y_mag;
            dec_in.xm        = x_mag;
            dec_in.side.yneg = in_req_ff.y_value[OPERAND_W-1];
            dec_in.side.xneg = in_req_ff.x_value[OPERAND_W-1];
         end
         ACT_ASIN, ACT_ACOS: begin
            dec_in.side.derr    = x_mag > OPERAND_ONE;
            dec_in.side.yneg    = in_req_ff.x_value[OPERAND_W-1];
            dec_in.side.is_acos = in_req_ff.action == ACT_ACOS;
            dec_in.use_root     = 1'b1;
            // out-of-domain operands go through as zero, the angle is dropped later
            if (!dec_in.side.derr) begin
               dec_in.big = (RATIO_FRAC + 1)'(x_mag << (RATIO_FRAC - OPERAND_FRAC_BITS));
            end
            dec_in.ym = OPERAND_W'(dec_in.big);
         end
         default: begin
            dec_in = '0;
         end
      endcase
   end

   // radicand 2^60 - X^2 for the cosine
   always_comb begin
      logic [ROOT_W-1:0] big_sq;
      big_sq = ROOT_W'(dec_ff.big) * ROOT_W'(dec_ff.big);
      root_in.rad      = RAD_W'((ROOT_W'(1) << (2 * RATIO_FRAC)) - big_sq);
      root_in.res      = '0;
      root_in.ym       = dec_ff.ym;
      root_in.xm       = dec_ff.xm;
      root_in.use_root = dec_ff.use_root;
      root_in.side     = dec_ff.side;
   end

   // ---------------------------------------------------------------- ratio setup
   // magnitude ratio min/max in Q1.30, flip when the numerator is the larger
   always_comb begin
      logic [OPERAND_W-1:0] n;
      logic [OPERAND_W-1:0] d;
      logic [OPERAND_W-1:0] num_r;
      logic [OPERAND_W-1:0] den_r;
      n = root_ff[ROOT_STEPS].ym;
      d = root_ff[ROOT_STEPS].use_root ? root_ff[ROOT_STEPS].res[OPERAND_W-1:0]
                                       : root_ff[ROOT_STEPS].xm;
      pre_in.valid          = root_vld_ff[ROOT_STEPS];
      pre_in.side           = root_ff[ROOT_STEPS].side;
      pre_in.side.zero_pair = (n == '0) && (d == '0);
      pre_in.side.x_zero    = d == '0;
      pre_in.side.flip      = n > d;
      num_r = pre_in.side.flip ? d : n;
      den_r = pre_in.side.flip ? n : d;
      pre_in.dividend = (DIVIDEND_W'(num_r) << RATIO_FRAC) + DIVIDEND_W'(den_r >> 1);
      // zero divisor only with x zero, whose angle is fixed anyway
      pre_in.divisor  = (den_r == '0) ? DIVISOR_W'(1) : den_r;
   end

   cfatan_div u_ratio_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (pre_ff),
      .div_rsp (ratio_rsp)
   );

   // ---------------------------------------------------------------- u squared
   always_comb begin
      logic [2*QUOT_W-1:0] u_sq;
      u_sq = (2 * QUOT_W)'(ratio_rsp.quotient) * (2 * QUOT_W)'(ratio_rsp.quotient)
             + ((2 * QUOT_W)'(1) << (SQ_SHIFT - 1));
      sq_side_in    = ratio_rsp.side;
      sq_side_in.u  = ratio_rsp.quotient;
      sq_side_in.sq = u_sq[SQ_SHIFT +: SQ_W];
   end

   // ---------------------------------------------------------------- fraction terms
   // innermost term first, c starts at zero
   always_comb begin
      term_out[0].valid    = sq_vld_ff;
      term_out[0].quotient = '0;
      term_out[0].side     = sq_side_ff;
   end

   for (genvar t = 0; t < FRACTION_TERMS; t++) begin : g_term
      cfatan_div u_term_div (
         .clock   (clock),
         .reset   (reset),
         .div_req (term_req_ff[t]),
         .div_rsp (term_out[t+1])
      );
   end

   // arctangent of u = u 2^22 / (2^24 + c), Q28
   always_comb begin
      logic [DIVISOR_W-1:0] d;
      d = DIVISOR_W'(1 << CF_FRAC)
          + DIVISOR_W'(term_out[FRACTION_TERMS].quotient[C_W-1:0]);
      fin_in.valid    = term_out[FRACTION_TERMS].valid;
      fin_in.side     = term_out[FRACTION_TERMS].side;
      fin_in.divisor  = d;
      fin_in.dividend = (DIVIDEND_W'(term_out[FRACTION_TERMS].side.u) << ATAN_SHIFT)
                        + DIVIDEND_W'(d >> 1);
   end

   cfatan_div u_final_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (fin_ff),
      .div_rsp (fin_rsp)
   );

   // ---------------------------------------------------------------- quadrant fixup
   always_comb begin
      logic signed [ANGLE_W-1:0] q;
      q = signed'(ANGLE_W'(fin_rsp.quotient));
      p1_angle_in = fin_rsp.side.flip ? HALF_PI_Q28 - q : q;
   end

   always_comb begin
      logic signed [ANGLE_W-1:0] pos;
      pos = p1_side_ff.xneg ? PI_Q28 - p1_angle_ff : p1_angle_ff;
      p2_angle_in = p1_side_ff.yneg ? -pos : pos;
      if (p1_side_ff.x_zero) begin
         p2_angle_in = p1_side_ff.yneg ? -HALF_PI_Q28 : HALF_PI_Q28;
      end
      if (p1_side_ff.zero_pair) begin
         p2_angle_in = '0;
      end
   end

   // acos is pi/2 - asin, domain errors give angle zero
   always_comb begin
      rsp_in.domain_error = p2_side_ff.derr;
      rsp_in.angle        = p2_side_ff.is_acos ? HALF_PI_Q28 - p2_angle_ff : p2_angle_ff;
      if (p2_side_ff.derr) begin
         rsp_in.angle = '0;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         in_vld_ff   <= 1'b0;
         dec_vld_ff  <= 1'b0;
         root_vld_ff <= '0;
         sq_vld_ff   <= 1'b0;
         p1_vld_ff   <= 1'b0;
         p2_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         // valid bits inside the divider requests
         pre_ff.valid <= 1'b0;
         fin_ff.valid <= 1'b0;
         for (int t = 0; t < FRACTION_TERMS; t++) begin
            term_req_ff[t].valid <= 1'b0;
         end
      end else begin
         busy_ff     <= 1'b0;
         in_vld_ff   <= start && !busy_ff;
         dec_vld_ff  <= in_vld_ff;
         root_vld_ff <= {root_vld_ff[ROOT_STEPS-1:0], dec_vld_ff};
         sq_vld_ff   <= ratio_rsp.valid;
         p1_vld_ff   <= fin_rsp.valid;
         p2_vld_ff   <= p1_vld_ff;
         rsp_vld_ff  <= p2_vld_ff;
         pre_ff      <= pre_in;
         for (int t = 0; t < FRACTION_TERMS; t++) begin
            term_req_ff[t] <= term_req(term_out[t], FRACTION_TERMS - t);
         end
         fin_ff      <= fin_in;
      end

      in_req_ff  <= req_payload;
      dec_ff     <= dec_in;
      root_ff[0] <= root_in;
      for (int j = 0; j < ROOT_STEPS; j++) begin
         root_ff[j+1] <= root_step(root_ff[j], ROOT_STEPS - 1 - j);
      end
      sq_side_ff  <= sq_side_in;
      p1_angle_ff <= p1_angle_in;
      p1_side_ff  <= fin_rsp.side;
      p2_angle_ff <= p2_angle_in;
      p2_side_ff  <= p1_side_ff;
      rsp_ff      <= rsp_in;
   end

`ifndef ASSERT_OFF
   // every result strobe comes from a transaction taken a fixed time earlier
   a_strobe_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a matching transaction");

   // domain errors only for asin and acos
   a_derr_action: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.domain_error |->
      $past(req_payload.action == ACT_ASIN || req_payload.action == ACT_ACOS, LATENCY))
      else $error("domain error on atan or atan2");

   // plain atan stays within plus or minus pi/2
   a_atan_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(req_payload.action == ACT_ATAN, LATENCY) |->
      rsp_payload.angle <= HALF_PI_Q28 && rsp_payload.angle >= -HALF_PI_Q28)
      else $error("atan result out of range");
`endif

endmodule
